[hdl/avcc_param_set_base64_extract_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the decoder configuration record extractor.
// Every macro samples on the rising edge of clk and is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AVCC_PARAM_SET_BASE64_EXTRACT_MACROS_SVH
`define AVCC_PARAM_SET_BASE64_EXTRACT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AVCCB64_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AVCCB64_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/avccb64_pkg.sv]
// ----------------------------------------------------------------------------
// avccb64_pkg
// Types, codes and the Base64 alphabet shared by the extractor modules.
// ----------------------------------------------------------------------------
package avccb64_pkg;

	// Most results one record byte can produce: two characters, two padding
	// characters and a status.
	localparam int MaxRun = 5;

	// Values of set_kind.
	localparam logic [1:0] KIND_SPS    = 2'd0;
	localparam logic [1:0] KIND_PPS    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Values of status_code.
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_TRUNC  = 3'd1;
	localparam logic [2:0] ST_NO_SPS = 3'd2;
	localparam logic [2:0] ST_NO_PPS = 3'd3;
	localparam logic [2:0] ST_EMPTY  = 3'd4;

	// ASCII '=' used as Base64 padding.
	localparam logic [6:0] CH_PAD = 7'h3D;

	// One result beat.
	typedef struct packed {
		logic [6:0] out_char;
		logic [1:0] set_kind;
		logic       set_end;
		logic [2:0] status_code;
		logic       last_of_run;
	} out_beat_t;

	// All results caused by one record byte, with their count.
	typedef struct packed {
		logic [2:0]                    cnt;
		out_beat_t [MaxRun-1:0]        ents;
	} run_t;

	// Standard Base64 alphabet.
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] w;
		w = {1'b0, v};
		if (v < 6'd26)
			return 7'h41 + w;
		else if (v < 6'd52)
			return 7'h61 + w - 7'd26;
		else if (v < 6'd62)
			return 7'h30 + w - 7'd52;
		else if (v == 6'd62)
			return 7'h2B;
		else
			return 7'h2F;
	endfunction

	// A character result of the given set.
	function automatic out_beat_t mk_char(input logic [6:0] ch, input logic [1:0] kind);
		out_beat_t r;
		r = '0;
		r.out_char = ch;
		r.set_kind = kind;
		return r;
	endfunction

endpackage

[hdl/avccb64_rec_if.sv]
// ----------------------------------------------------------------------------
// avccb64_rec_if
// Record byte channel: one byte of the configuration record per beat.
// ----------------------------------------------------------------------------
interface avccb64_rec_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       record_end;

	modport source(output valid, data_byte, record_end, input ready);
	modport sink(input valid, data_byte, record_end, output ready);
endinterface

[hdl/avccb64_res_if.sv]
// ----------------------------------------------------------------------------
// avccb64_res_if
// Result channel: one Base64 character or one status per beat.
// ----------------------------------------------------------------------------
interface avccb64_res_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic [1:0] set_kind;
	logic       set_end;
	logic [2:0] status_code;
	logic       last_of_run;

	modport source(output valid, out_char, set_kind, set_end, status_code, last_of_run,
		input ready);
	modport sink(input valid, out_char, set_kind, set_end, status_code, last_of_run,
		output ready);
endinterface

[hdl/avccb64_parse.sv]
// ----------------------------------------------------------------------------
// avccb64_parse
// Record parser and Base64 encoder. Holds the parse state and, for each
// accepted byte, builds the complete list of results that byte causes.
// ----------------------------------------------------------------------------
`include "avcc_param_set_base64_extract_macros.svh"

module avccb64_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                record_end,
	output avccb64_pkg::run_t   run
);

	// Parse phases.
	localparam logic [3:0] PH_HEADER    = 4'd0;
	localparam logic [3:0] PH_SPS_COUNT = 4'd1;
	localparam logic [3:0] PH_SPS_HI    = 4'd2;
	localparam logic [3:0] PH_SPS_LO    = 4'd3;
	localparam logic [3:0] PH_SPS_DATA  = 4'd4;
	localparam logic [3:0] PH_PPS_COUNT = 4'd5;
	localparam logic [3:0] PH_PPS_HI    = 4'd6;
	localparam logic [3:0] PH_PPS_LO    = 4'd7;
	localparam logic [3:0] PH_PPS_DATA  = 4'd8;
	localparam logic [3:0] PH_DONE      = 4'd9;
	localparam logic [3:0] PH_FAILED    = 4'd10;

	localparam logic [2:0] HeaderBytes = 3'd5;

	logic [3:0]  phase_q, phase_d;
	logic [2:0]  hc_q, hc_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  hi_q, hi_d;
	logic [3:0]  lb_q, lb_d;
	logic [1:0]  tp_q, tp_d;
	logic [2:0]  err_q, err_d;
	logic        empty_q, empty_d;
	logic        early;
	logic [1:0]  kind;
	logic [2:0]  n;
	logic [2:0]  st;
	avccb64_pkg::run_t run_d;

	// Next state and result list for the byte on the input.
	always_comb begin
		phase_d = phase_q;
		hc_d    = hc_q;
		len_d   = len_q;
		hi_d    = hi_q;
		lb_d    = lb_q;
		tp_d    = tp_q;
		err_d   = err_q;
		empty_d = empty_q;
		run_d   = '0;
		n       = '0;
		st      = avccb64_pkg::ST_OK;
		kind    = (phase_q == PH_PPS_DATA) ? avccb64_pkg::KIND_PPS : avccb64_pkg::KIND_SPS;
		early   = (phase_q == PH_HEADER) || (phase_q == PH_SPS_COUNT);

		case (phase_q)
			PH_HEADER: begin
				hc_d = hc_q + 3'd1;
				if (hc_d >= HeaderBytes) begin
					hc_d    = '0;
					phase_d = PH_SPS_COUNT;
				end
			end
			PH_SPS_COUNT: begin
				if (data_byte[4:0] == 5'd0) begin
					err_d   = avccb64_pkg::ST_NO_SPS;
					phase_d = PH_FAILED;
				end else begin
					phase_d = PH_SPS_HI;
				end
			end
			PH_PPS_COUNT: begin
				if (data_byte == 8'd0) begin
					err_d   = avccb64_pkg::ST_NO_PPS;
					phase_d = PH_FAILED;
				end else begin
					phase_d = PH_PPS_HI;
				end
			end
			PH_SPS_HI, PH_PPS_HI: begin
				hi_d    = data_byte;
				phase_d = (phase_q == PH_SPS_HI) ? PH_SPS_LO : PH_PPS_LO;
			end
			PH_SPS_LO, PH_PPS_LO: begin
				len_d = {hi_q, data_byte};
				lb_d  = '0;
				tp_d  = '0;
				if (len_d == 16'd0) begin
					empty_d = 1'b1;
					phase_d = (phase_q == PH_SPS_LO) ? PH_PPS_COUNT : PH_DONE;
				end else begin
					phase_d = (phase_q == PH_SPS_LO) ? PH_SPS_DATA : PH_PPS_DATA;
				end
			end
			PH_SPS_DATA, PH_PPS_DATA: begin
				// Encode one payload byte into the running 3-byte group.
				case (tp_q)
					2'd0: begin
						run_d.ents[n] = avccb64_pkg::mk_char(
							avccb64_pkg::b64_char(data_byte[7:2]), kind);
						n    = n + 3'd1;
						lb_d = {2'b00, data_byte[1:0]};
						tp_d = 2'd1;
					end
					2'd1: begin
						run_d.ents[n] = avccb64_pkg::mk_char(
							avccb64_pkg::b64_char({lb_q[1:0], data_byte[7:4]}), kind);
						n    = n + 3'd1;
						lb_d = data_byte[3:0];
						tp_d = 2'd2;
					end
					default: begin
						run_d.ents[n] = avccb64_pkg::mk_char(
							avccb64_pkg::b64_char({lb_q, data_byte[7:6]}), kind);
						n = n + 3'd1;
						run_d.ents[n] = avccb64_pkg::mk_char(
							avccb64_pkg::b64_char(data_byte[5:0]), kind);
						n    = n + 3'd1;
						lb_d = '0;
						tp_d = 2'd0;
					end
				endcase
				len_d = len_q - 16'd1;
				// Last payload byte: close any open group with padding and mark the set's end.
				if (len_d == 16'd0) begin
					case (tp_d)
						2'd1: begin
							run_d.ents[n] = avccb64_pkg::mk_char(
								avccb64_pkg::b64_char({lb_d[1:0], 4'b0000}), kind);
							n = n + 3'd1;
							run_d.ents[n] = avccb64_pkg::mk_char(avccb64_pkg::CH_PAD, kind);
							n = n + 3'd1;
							run_d.ents[n] = avccb64_pkg::mk_char(avccb64_pkg::CH_PAD, kind);
							n = n + 3'd1;
						end
						2'd2: begin
							run_d.ents[n] = avccb64_pkg::mk_char(
								avccb64_pkg::b64_char({lb_d, 2'b00}), kind);
							n = n + 3'd1;
							run_d.ents[n] = avccb64_pkg::mk_char(avccb64_pkg::CH_PAD, kind);
							n = n + 3'd1;
						end
						default: begin
						end
					endcase
					run_d.ents[n - 3'd1].set_end = 1'b1;
					lb_d    = '0;
					tp_d    = '0;
					phase_d = (phase_q == PH_SPS_DATA) ? PH_PPS_COUNT : PH_DONE;
				end
			end
			default: begin
			end
		endcase

		// Final byte: append the status and return to the start state.
		if (record_end) begin
			if (early)
				st = avccb64_pkg::ST_TRUNC;
			else if (err_d != avccb64_pkg::ST_OK)
				st = err_d;
			else if (phase_d != PH_DONE)
				st = avccb64_pkg::ST_TRUNC;
			else if (empty_d)
				st = avccb64_pkg::ST_EMPTY;
			else
				st = avccb64_pkg::ST_OK;
			run_d.ents[n]             = '0;
			run_d.ents[n].set_kind    = avccb64_pkg::KIND_STATUS;
			run_d.ents[n].status_code = st;
			n       = n + 3'd1;
			phase_d = PH_HEADER;
			hc_d    = '0;
			len_d   = '0;
			hi_d    = '0;
			lb_d    = '0;
			tp_d    = '0;
			err_d   = avccb64_pkg::ST_OK;
			empty_d = 1'b0;
		end

		if (n != 3'd0)
			run_d.ents[n - 3'd1].last_of_run = 1'b1;
		run_d.cnt = n;
	end

	assign run = run_d;

	// Parse state advances once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hc_q    <= '0;
			len_q   <= '0;
			hi_q    <= '0;
			lb_q    <= '0;
			tp_q    <= '0;
			err_q   <= avccb64_pkg::ST_OK;
			empty_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			hc_q    <= hc_d;
			len_q   <= len_d;
			hi_q    <= hi_d;
			lb_q    <= lb_d;
			tp_q    <= tp_d;
			err_q   <= err_d;
			empty_q <= empty_d;
		end
	end

	`AVCCB64_ASSERT_NEXT(a_end_restarts, accept && record_end, (phase_q == PH_HEADER) && (hc_q == 3'd0) && (err_q == avccb64_pkg::ST_OK), "record end did not restart the parser")
	`AVCCB64_ASSERT_SAME(a_group_in_range, 1'b1, tp_q != 2'd3, "Base64 group position out of range")

endmodule

[hdl/avccb64_emit.sv]
// ----------------------------------------------------------------------------
// avccb64_emit
// Result register: holds the results of one record byte and hands them out
// one beat at a time. Takes a new byte as the last result leaves.
// ----------------------------------------------------------------------------
`include "avcc_param_set_base64_extract_macros.svh"

module avccb64_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  avccb64_pkg::run_t   run,
	output logic                in_ready,
	avccb64_res_if.source       result
);

	avccb64_pkg::out_beat_t [avccb64_pkg::MaxRun-1:0] ents_q;
	logic [2:0] cnt_q;
	logic [2:0] idx_q;
	logic       pop;
	avccb64_pkg::out_beat_t cur;

	assign cur  = ents_q[idx_q];
	assign pop  = result.valid && result.ready;

	// Free now, or free once the final result leaves in this cycle.
	assign in_ready = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && result.ready);

	assign result.valid       = (cnt_q != 3'd0);
	assign result.out_char    = cur.out_char;
	assign result.set_kind    = cur.set_kind;
	assign result.set_end     = cur.set_end;
	assign result.status_code = cur.status_code;
	assign result.last_of_run = cur.last_of_run;

	// Result list payload.
	always_ff @(posedge clk) begin
		if (load && (run.cnt != 3'd0))
			ents_q <= run.ents;
	end

	// Count of results still to send and the read position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load && (run.cnt != 3'd0)) begin
			cnt_q <= run.cnt;
			idx_q <= '0;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
			idx_q <= idx_q + 3'd1;
		end
	end

	`AVCCB64_ASSERT_SAME(a_run_in_bounds, cnt_q != 3'd0, ({1'b0, idx_q} + {1'b0, cnt_q}) <= 4'd5, "result position beyond the stored list")
	`AVCCB64_ASSERT_SAME(a_last_marked, cnt_q == 3'd1, cur.last_of_run, "final result of a byte lacks last_of_run")
	`AVCCB64_ASSERT_SAME(a_ready_when_empty, cnt_q == 3'd0, in_ready, "input stalled with no results pending")

endmodule

[hdl/avcc_param_set_base64_extract.sv]
// ----------------------------------------------------------------------------
// avcc_param_set_base64_extract
// Pulls the first SPS and first PPS out of an H.264 decoder configuration
// record and sends each as Base64 characters, then a status on the last byte.
//
// Channel   Dir   Beat contents
// record    in    data_byte, record_end
// result    out   out_char, set_kind, set_end, status_code, last_of_run
//
// A record byte is parsed in the cycle it is accepted; its results (zero to
// five) sit in the result register and leave one per cycle when not stalled.
// A byte that causes no results leaves the input ready; otherwise the next
// byte is accepted in the cycle its predecessor's last result leaves.
// Reset returns the parser to the header phase and empties the result register.
// A stall on result holds the current beat and stops new record bytes.
// ----------------------------------------------------------------------------
module avcc_param_set_base64_extract (
	input  logic            clk,
	input  logic            arst_n,
	avccb64_rec_if.sink     record,
	avccb64_res_if.source   result
);

	logic               rdy;
	logic               accept;
	avccb64_pkg::run_t  run;

	assign record.ready = rdy;
	assign accept       = record.valid && rdy;

	// Parser and encoder.
	avccb64_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (record.data_byte),
		.record_end (record.record_end),
		.run        (run)
	);

	// Result register and serializer.
	avccb64_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.run      (run),
		.in_ready (rdy),
		.result   (result)
	);

endmodule
